[hdl/sbpd_pkg.sv]
// ----------------------------------------------------------------------------
// sbpd_pkg
// Shared constants, tables and control types of the spectrum band peak meter.
// ----------------------------------------------------------------------------
package sbpd_pkg;

   localparam int BAND_COUNT          = 16;
   localparam int MAGNITUDE_BITS_DEF  = 32;
   localparam int BIN_BITS            = 9;
   localparam int BAND_BITS           = 4;
   localparam int LEVEL_BITS          = 12;
   localparam int SCALE_BITS          = 16;
   localparam int NORM_STEPS          = 5;
   localparam int STEP_BITS           = 3;

   localparam logic [1:0]            ADDR_RECIPROCAL_SCALE = 2'd0;

   localparam logic [BIN_BITS-1:0]   BIN_LIMIT       = 9'd510;
   localparam logic [BIN_BITS-1:0]   POS_MAX         = 9'd511;
   localparam logic [SCALE_BITS-1:0] SCALE_RESET     = 16'd10923;
   localparam logic [17:0]           DB_PER_OCTAVE   = 18'd197283;
   localparam logic [20:0]           LOG2_FULL_SCALE = 21'd1048574;
   localparam logic [LEVEL_BITS-1:0] LEVEL_MAX       = 12'd4095;

   localparam logic [BIN_BITS-1:0] LAST_BIN [BAND_COUNT] = '{
      9'd1,   9'd3,   9'd5,   9'd9,   9'd13,  9'd19,  9'd27,  9'd39,
      9'd55,  9'd79,  9'd107, 9'd147, 9'd201, 9'd273, 9'd373, 9'd509
   };

   localparam logic [16:0] FRAC_LOG [17] = '{
      17'd0,     17'd5732,  17'd11136, 17'd16248, 17'd21098, 17'd25711,
      17'd30109, 17'd34312, 17'd38336, 17'd42196, 17'd45904, 17'd49472,
      17'd52911, 17'd56229, 17'd59434, 17'd62534, 17'd65536
   };

   typedef struct packed {
      logic                 accept;
      logic                 load_flush;
      logic                 finish;
      logic                 norm;
      logic [STEP_BITS-1:0] norm_step;
      logic                 frac;
      logic                 diff;
      logic                 scale;
      logic                 mul_lo;
      logic                 mul_hi;
      logic                 out_load;
   } sbpd_cmd_type;

   typedef struct packed {
      logic emit;
      logic band_pending;
      logic out_free;
   } sbpd_status_type;

endpackage

[hdl/sbpd_ctl.sv]
// ----------------------------------------------------------------------------
// sbpd_ctl
// Sequencer that accepts bins and steps the level datapath for each band.
// ----------------------------------------------------------------------------
module sbpd_ctl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   input  logic                     req_tlast,
   output logic                     req_tready,
   input  sbpd_pkg::sbpd_status_type status,
   output sbpd_pkg::sbpd_cmd_type    cmd
);

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b00000001,
      ST_NORM   = 8'b00000010,
      ST_FRAC   = 8'b00000100,
      ST_DIFF   = 8'b00001000,
      ST_SCALE  = 8'b00010000,
      ST_MUL_LO = 8'b00100000,
      ST_MUL_HI = 8'b01000000,
      ST_OUTPUT = 8'b10000000
   } state_type;

   state_type                      state_ff, state_in;
   logic [sbpd_pkg::STEP_BITS-1:0] step_ff, step_in;
   logic                           flush_ff, flush_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      flush_in = flush_ff;
      cmd      = '0;
      cmd.norm_step = step_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               if (status.emit) begin
                  flush_in = req_tlast;
                  step_in  = '0;
                  state_in = ST_NORM;
               end
            end
         end
         ST_NORM: begin
            cmd.norm = 1'b1;
            if (step_ff == sbpd_pkg::STEP_BITS'(sbpd_pkg::NORM_STEPS - 1)) begin
               state_in = ST_FRAC;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_FRAC: begin
            cmd.frac = 1'b1;
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            cmd.diff = 1'b1;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_MUL_LO;
         end
         ST_MUL_LO: begin
            cmd.mul_lo = 1'b1;
            state_in   = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            cmd.mul_hi = 1'b1;
            state_in   = ST_OUTPUT;
         end
         ST_OUTPUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               if (flush_ff && status.band_pending) begin
                  cmd.load_flush = 1'b1;
                  step_in        = '0;
                  state_in       = ST_NORM;
               end else begin
                  cmd.finish = flush_ff;
                  flush_in   = 1'b0;
                  state_in   = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
            flush_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         flush_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         flush_ff <= flush_in;
      end
   end

endmodule

[hdl/sbpd_dp.sv]
// ----------------------------------------------------------------------------
// sbpd_dp
// Band tracking, running peak, log2 level arithmetic and the result register.
// ----------------------------------------------------------------------------
module sbpd_dp #(
   parameter int MAGNITUDE_BITS = sbpd_pkg::MAGNITUDE_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  sbpd_pkg::sbpd_cmd_type           cmd,
   output sbpd_pkg::sbpd_status_type        status,
   input  logic [31:0]                      req_tdata,
   input  logic                             req_tlast,
   input  logic [sbpd_pkg::SCALE_BITS-1:0]  reciprocal_scale,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [15:0]                      rsp_tdata,
   output logic                             rsp_tlast
);

   localparam int PEAK_BITS = (MAGNITUDE_BITS < 32) ? MAGNITUDE_BITS : 32;
   localparam int EXP_BITS  = $clog2(PEAK_BITS);
   localparam int D_BITS    = EXP_BITS + 16;
   localparam int Q_BITS    = D_BITS + sbpd_pkg::SCALE_BITS;
   localparam int LO_BITS   = 20;
   localparam int HI_BITS   = Q_BITS - LO_BITS;
   localparam int P_BITS    = Q_BITS + 18;
   localparam int R_BITS    = P_BITS - 39;

   logic [sbpd_pkg::BIN_BITS-1:0]  pos_ff, pos_in;
   logic [sbpd_pkg::BAND_BITS:0]   band_ff, band_in;
   logic [PEAK_BITS-1:0]           peak_ff, peak_in;
   logic [sbpd_pkg::BAND_BITS-1:0] emit_band_ff, emit_band_in;

   logic [PEAK_BITS-1:0] mag;
   logic                 in_band;
   logic                 hit;
   logic [PEAK_BITS-1:0] peak_upd;

   logic [PEAK_BITS-1:0] x_ff;
   logic [EXP_BITS-1:0]  e_ff;
   logic                 small_ff;
   logic [16:0]          base_ff;
   logic [12:0]          interp_ff;
   logic [D_BITS-1:0]    d_ff;
   logic [Q_BITS-1:0]    q_ff;
   logic [LO_BITS+17:0]  plo_ff;
   logic [P_BITS-1:0]    p_ff;

   logic [EXP_BITS-1:0]  shift_amt;
   logic [15:0]          mant;
   logic [3:0]           frac_k;
   logic [11:0]          frac_f;
   logic [16:0]          tab_lo;
   logic [16:0]          tab_hi;
   logic [24:0]          interp_full;
   logic [D_BITS:0]      lg;
   logic [HI_BITS+17:0]  phi;
   logic [R_BITS:0]      rnd;
   logic [R_BITS-1:0]    lvl_full;
   logic [sbpd_pkg::LEVEL_BITS-1:0] lvl;

   logic                 out_valid_ff;
   logic [15:0]          out_data_ff;
   logic                 out_last_ff;

   assign mag      = req_tdata[PEAK_BITS-1:0];
   assign in_band  = (pos_ff < sbpd_pkg::BIN_LIMIT) && !band_ff[sbpd_pkg::BAND_BITS];
   assign hit      = in_band &&
                     (pos_ff == sbpd_pkg::LAST_BIN[band_ff[sbpd_pkg::BAND_BITS-1:0]]);
   assign peak_upd = (in_band && (mag > peak_ff)) ? mag : peak_ff;

   assign status.emit         = hit || (req_tlast && !band_ff[sbpd_pkg::BAND_BITS]);
   assign status.band_pending = !band_ff[sbpd_pkg::BAND_BITS];
   assign status.out_free     = !out_valid_ff || rsp_tready;

   always_comb begin
      pos_in       = pos_ff;
      band_in      = band_ff;
      peak_in      = peak_ff;
      emit_band_in = emit_band_ff;
      if (cmd.accept) begin
         if (req_tlast) begin
            pos_in = '0;
         end else if (pos_ff != sbpd_pkg::POS_MAX) begin
            pos_in = pos_ff + 1'b1;
         end
         if (status.emit) begin
            emit_band_in = band_ff[sbpd_pkg::BAND_BITS-1:0];
            band_in      = band_ff + 1'b1;
            peak_in      = '0;
         end else if (req_tlast) begin
            band_in = '0;
            peak_in = '0;
         end else begin
            peak_in = peak_upd;
         end
      end else if (cmd.load_flush) begin
         emit_band_in = band_ff[sbpd_pkg::BAND_BITS-1:0];
         band_in      = band_ff + 1'b1;
      end else if (cmd.finish) begin
         band_in = '0;
         peak_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         band_ff <= '0;
         peak_ff <= '0;
      end else begin
         pos_ff  <= pos_in;
         band_ff <= band_in;
         peak_ff <= peak_in;
      end
      emit_band_ff <= emit_band_in;
   end

   assign shift_amt   = EXP_BITS'(1) << (sbpd_pkg::NORM_STEPS - 1 - int'(cmd.norm_step));
   assign mant        = x_ff[PEAK_BITS-2 -: 16];
   assign frac_k      = mant[15:12];
   assign frac_f      = mant[11:0];
   assign tab_lo      = sbpd_pkg::FRAC_LOG[frac_k];
   assign tab_hi      = sbpd_pkg::FRAC_LOG[5'(frac_k) + 5'd1];
   assign interp_full = 25'(tab_hi - tab_lo) * 25'(frac_f);
   assign lg          = (D_BITS+1)'({e_ff, 16'd0}) + (D_BITS+1)'(base_ff)
                        + (D_BITS+1)'(interp_ff);
   assign phi         = (HI_BITS+18)'(q_ff[Q_BITS-1:LO_BITS]) *
                        (HI_BITS+18)'(sbpd_pkg::DB_PER_OCTAVE);

   always_ff @(posedge clock) begin
      if (cmd.accept || cmd.load_flush) begin
         x_ff     <= cmd.accept ? peak_upd : '0;
         e_ff     <= EXP_BITS'(PEAK_BITS - 1);
         small_ff <= cmd.accept ? (peak_upd[PEAK_BITS-1:16] == '0) : 1'b1;
      end else if (cmd.norm) begin
         if ((x_ff >> (PEAK_BITS - int'(shift_amt))) == '0) begin
            x_ff <= x_ff << shift_amt;
            e_ff <= e_ff - shift_amt;
         end
      end
      if (cmd.frac) begin
         base_ff   <= tab_lo;
         interp_ff <= interp_full[24:12];
      end
      if (cmd.diff) begin
         d_ff <= D_BITS'(lg - (D_BITS+1)'(sbpd_pkg::LOG2_FULL_SCALE));
      end
      if (cmd.scale) begin
         q_ff <= Q_BITS'(d_ff) * Q_BITS'(reciprocal_scale);
      end
      if (cmd.mul_lo) begin
         plo_ff <= (LO_BITS+18)'(q_ff[LO_BITS-1:0]) *
                   (LO_BITS+18)'(sbpd_pkg::DB_PER_OCTAVE);
      end
      if (cmd.mul_hi) begin
         p_ff <= (P_BITS'(phi) << LO_BITS) + P_BITS'(plo_ff);
      end
   end

   assign rnd      = (R_BITS+1)'(p_ff[P_BITS-1:39]) + 1'b1;
   assign lvl_full = rnd[R_BITS:1];

   always_comb begin
      if (small_ff) begin
         lvl = '0;
      end else if (lvl_full > R_BITS'(sbpd_pkg::LEVEL_MAX)) begin
         lvl = sbpd_pkg::LEVEL_MAX;
      end else begin
         lvl = lvl_full[sbpd_pkg::LEVEL_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         out_data_ff <= {lvl, emit_band_ff};
         out_last_ff <= (emit_band_ff == sbpd_pkg::BAND_BITS'(sbpd_pkg::BAND_COUNT - 1));
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

[hdl/spectrum_band_peak_db.sv]
// ----------------------------------------------------------------------------
// spectrum_band_peak_db
// Peak level meter over sixteen log-spaced bands of one spectrum frame.
// A bin that closes no band is taken at once; the next can follow at once.
// A bin that closes a band blocks input until its result is loaded into the
// result register after the five-step normalizer and the multiplier chain,
// which a stalled output delays. At frame end each remaining band does the same.
// Synchronous reset clears the band state and sets the scale to 10923.
// ----------------------------------------------------------------------------
module spectrum_band_peak_db #(
   parameter int MAGNITUDE_BITS = sbpd_pkg::MAGNITUDE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,    // bin_magnitude
   input  logic        req_tlast,    // frame_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,    // band_number [3:0], band_level [15:4]
   output logic        rsp_tlast,    // frame_done
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [sbpd_pkg::SCALE_BITS-1:0] scale_ff;
   sbpd_pkg::sbpd_cmd_type          cmd;
   sbpd_pkg::sbpd_status_type       status;

   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= sbpd_pkg::SCALE_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite &&
                   (csr_paddr == sbpd_pkg::ADDR_RECIPROCAL_SCALE)) begin
         scale_ff <= csr_pwdata[sbpd_pkg::SCALE_BITS-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr == sbpd_pkg::ADDR_RECIPROCAL_SCALE) begin
         csr_prdata = 32'(scale_ff);
      end
   end

   sbpd_ctl u_ctl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   sbpd_dp #(
      .MAGNITUDE_BITS (MAGNITUDE_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_tdata        (req_tdata),
      .req_tlast        (req_tlast),
      .reciprocal_scale (scale_ff),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .rsp_tlast        (rsp_tlast)
   );

endmodule

[hdl/sbpd_checker.sv]
// ----------------------------------------------------------------------------
// sbpd_checker
// Port-level checks of the band peak meter, bound to the top level.
// ----------------------------------------------------------------------------
module sbpd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic        csr_pready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("Stalled result changed before its transfer.");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("Result valid right after reset.");

   a_last_band: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tdata[3:0] == 4'd15)))
      else $error("Frame done flag does not match the final band.");

   a_known_handshake: assert property (@(posedge clock) disable iff (reset)
      !$isunknown({req_tvalid, req_tready, rsp_tvalid, rsp_tready}))
      else $error("Handshake signal unknown.");

   a_pready: assert property (@(posedge clock) disable iff (reset)
      csr_pready)
      else $error("Configuration port not ready.");

endmodule

bind spectrum_band_peak_db sbpd_checker u_sbpd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .csr_pready (csr_pready)
);

[dv/tb_spectrum_band_peak_db.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_spectrum_band_peak_db
// Self-checking bench for the band peak meter. Bin magnitudes are streamed in
// frame by frame and every band level is predicted from the bench's own copy
// of the band state and the fixed-point log arithmetic. Each result transfer
// is checked against the oldest prediction. The scale register is rewritten
// between phases, and both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_spectrum_band_peak_db;

   localparam int          CYCLE_LIMIT           = 400000;
   localparam int          SETTLE_CYCLES         = 200;
   localparam int          LONG_HOLD_CYCLES      = 400;
   localparam logic [15:0] SCALE_AT_RESET        = 16'd10923;
   localparam logic [63:0] FULL_SCALE            = 64'd65535;
   localparam logic [63:0] DB_PER_OCTAVE_Q16     = 64'd197283;
   localparam int          BANDS                 = 16;
   localparam int          LAST_IN_RANGE         = 510;
   localparam int          POSITION_CEILING      = 511;

   typedef struct packed {
      logic [31:0] magnitude;
      logic        frame_end;
   } bin_item_type;

   typedef struct packed {
      logic [3:0]  band;
      logic [11:0] level;
      logic        done;
   } band_result_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata   = '0;   // bin_magnitude
   logic        req_tlast   = 1'b0; // frame_end
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [15:0] rsp_tdata;          // band_number [3:0], band_level [15:4]
   logic        rsp_tlast;          // frame_done
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [1:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   bin_item_type    pending_bins[$];
   band_result_type expected_levels[$];

   logic [8:0]  frame_bin     = '0;
   logic [4:0]  open_band     = '0;
   logic [63:0] band_peak     = '0;
   logic [15:0] scale_setting = SCALE_AT_RESET;

   bit          idle_enabled  = 1'b1;
   bit          hold_request  = 1'b0;
   bit          hold_taken    = 1'b0;
   bit          failed        = 1'b0;
   int unsigned req_gap       = 0;
   int unsigned rsp_stall     = 0;
   int unsigned hold_left     = 0;
   int unsigned cycle_count   = 0;
   bin_item_type    next_bin;
   band_result_type oldest_level;

   spectrum_band_peak_db dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic logic [63:0] log_fraction(input int idx);
      case (idx)
         0:       return 64'd0;
         1:       return 64'd5732;
         2:       return 64'd11136;
         3:       return 64'd16248;
         4:       return 64'd21098;
         5:       return 64'd25711;
         6:       return 64'd30109;
         7:       return 64'd34312;
         8:       return 64'd38336;
         9:       return 64'd42196;
         10:      return 64'd45904;
         11:      return 64'd49472;
         12:      return 64'd52911;
         13:      return 64'd56229;
         14:      return 64'd59434;
         15:      return 64'd62534;
         default: return 64'd65536;
      endcase
   endfunction

   function automatic int band_bound(input int idx);
      case (idx)
         0:       return 0;
         1:       return 1;
         2:       return 2;
         3:       return 3;
         4:       return 5;
         5:       return 7;
         6:       return 10;
         7:       return 14;
         8:       return 20;
         9:       return 28;
         10:      return 40;
         11:      return 54;
         12:      return 74;
         13:      return 101;
         14:      return 137;
         15:      return 187;
         default: return 255;
      endcase
   endfunction

   function automatic logic [63:0] log2_q16(input logic [63:0] value);
      int          lead;
      int          k;
      logic [63:0] mant;
      logic [63:0] frac;
      lead = 63;
      while (lead > 0 && value[lead] == 1'b0) lead--;
      if (lead >= 16) begin
         mant = (value >> (lead - 16)) & 64'hFFFF;
      end else begin
         mant = (value << (16 - lead)) & 64'hFFFF;
      end
      k = int'(mant[15:12]);
      frac = {52'd0, mant[11:0]};
      return 64'(lead) * 64'd65536 + log_fraction(k)
             + (((log_fraction(k + 1) - log_fraction(k)) * frac) >> 12);
   endfunction

   function automatic logic [11:0] band_level_db(input logic [63:0] peak);
      logic [63:0] octaves;
      logic [63:0] product;
      logic [63:0] rounded;
      if (peak <= FULL_SCALE) return 12'd0;
      octaves = log2_q16(peak) - log2_q16(FULL_SCALE);
      product = octaves * DB_PER_OCTAVE_Q16 * {48'd0, scale_setting};
      rounded = (product + (64'd1 << 39)) >> 40;
      return (rounded > 64'd4095) ? 12'd4095 : rounded[11:0];
   endfunction

   task automatic close_band();
      band_result_type entry;
      entry.band  = open_band[3:0];
      entry.level = band_level_db(band_peak);
      entry.done  = (open_band == 5'd15);
      expected_levels.push_back(entry);
      open_band = open_band + 5'd1;
      band_peak = '0;
   endtask

   task automatic track_bin(input logic [31:0] magnitude, input logic frame_end);
      if (int'(frame_bin) < LAST_IN_RANGE && int'(open_band) < BANDS) begin
         if ({32'd0, magnitude} > band_peak) band_peak = {32'd0, magnitude};
         if (int'(frame_bin) == 2 * band_bound(int'(open_band) + 1) - 1) close_band();
      end
      if (frame_end) begin
         while (int'(open_band) < BANDS) close_band();
         frame_bin = '0;
         open_band = '0;
         band_peak = '0;
      end else if (int'(frame_bin) < POSITION_CEILING) begin
         frame_bin = frame_bin + 9'd1;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_tvalid && req_tready) track_bin(req_tdata, req_tlast);
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_bins.size() > 0) begin
               if (idle_enabled && $urandom_range(0, 7) == 0) begin
                  req_gap = $urandom_range(1, 12) - 1;
                  req_tvalid <= 1'b0;
               end else begin
                  next_bin = pending_bins.pop_front();
                  req_tvalid <= 1'b1;
                  req_tdata  <= next_bin.magnitude;
                  req_tlast  <= next_bin.frame_end;
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_levels.size() == 0) begin
               $display("%0t unexpected result: band %0d level %0d done %0d",
                        $time, rsp_tdata[3:0], rsp_tdata[15:4], rsp_tlast);
               failed = 1'b1;
            end else begin
               oldest_level = expected_levels.pop_front();
               if (rsp_tdata[3:0] !== oldest_level.band) begin
                  $display("%0t band_number mismatch: expected %0d actual %0d",
                           $time, oldest_level.band, rsp_tdata[3:0]);
                  failed = 1'b1;
               end
               if (rsp_tdata[15:4] !== oldest_level.level) begin
                  $display("%0t band_level mismatch (band %0d): expected %0d actual %0d",
                           $time, oldest_level.band, oldest_level.level, rsp_tdata[15:4]);
                  failed = 1'b1;
               end
               if (rsp_tlast !== oldest_level.done) begin
                  $display("%0t frame_done mismatch (band %0d): expected %0d actual %0d",
                           $time, oldest_level.band, oldest_level.done, rsp_tlast);
                  failed = 1'b1;
               end
            end
         end
         if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = LONG_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_tready <= 1'b0;
         end else if (idle_enabled && $urandom_range(0, 7) == 0) begin
            rsp_stall = $urandom_range(1, 12) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic logic [31:0] random_magnitude();
      case ($urandom_range(0, 7))
         0:       return 32'd0;
         1:       return $urandom_range(0, 65535);
         2:       return $urandom_range(65534, 65538);
         3:       return 32'hFFFF_FFFF;
         4:       return $urandom();
         5:       return $urandom() >> $urandom_range(0, 31);
         default: return $urandom() >> $urandom_range(0, 15);
      endcase
   endfunction

   task automatic push_bin(input logic [31:0] magnitude, input logic frame_end);
      bin_item_type entry;
      entry.magnitude = magnitude;
      entry.frame_end = frame_end;
      pending_bins.push_back(entry);
   endtask

   task automatic add_frame(input int unsigned length);
      int unsigned idx;
      for (idx = 0; idx < length; idx++) push_bin(random_magnitude(), idx == length - 1);
   endtask

   task automatic add_random_frames(input int unsigned budget);
      int unsigned count;
      int unsigned length;
      count = 0;
      while (count < budget) begin
         case ($urandom_range(0, 9))
            7, 8:    length = $urandom_range(25, 80);
            9:       length = $urandom_range(81, 300);
            default: length = $urandom_range(1, 24);
         endcase
         if (length > budget - count) length = budget - count;
         add_frame(length);
         count += length;
      end
   endtask

   task automatic wait_idle();
      while (pending_bins.size() != 0 || req_tvalid || expected_levels.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_scale(input logic [15:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= sbpd_pkg::ADDR_RECIPROCAL_SCALE;
      csr_pwdata  <= {16'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      scale_setting = value;
   endtask

   initial begin
      int unsigned n;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Band 0 at full magnitude, band 1 across the full-scale threshold,
      // then an early frame end that flushes a partial band and empty ones.
      push_bin(32'hFFFF_FFFF, 1'b0);
      push_bin(32'd0, 1'b0);
      push_bin(32'd65535, 1'b0);
      push_bin(32'd65536, 1'b0);
      push_bin(32'd65536, 1'b1);
      push_bin(32'd0, 1'b1);
      for (n = 0; n < 12; n++) push_bin(32'd1 << (2 * n + 8), n == 11);
      wait_idle();

      write_scale(16'hFFFF);
      push_bin(32'hFFFF_FFFF, 1'b0);
      push_bin(32'hFFFF_FFFE, 1'b0);
      push_bin(32'd65537, 1'b1);
      hold_request = 1'b1;
      add_random_frames(40);
      wait_idle();

      write_scale(16'd0);
      add_random_frames(20);
      wait_idle();

      write_scale(16'($urandom_range(1, 65535)));
      add_frame(202);
      wait_idle();

      write_scale(16'd1);
      add_random_frames(20);
      wait_idle();

      idle_enabled = 1'b0;
      write_scale(16'($urandom_range(0, 65535)));
      add_random_frames(20);
      wait_idle();

      if (!failed) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
